// ----- rtl/scd_pkg.sv -----
package scd_pkg;

    localparam int HEADER_BYTES            = 8;
    localparam int ALIVE_BYTES             = 4;
    localparam int MAX_PAYLOAD_LEN_DEFAULT = 127;

    localparam logic [2:0] ALIVE_LAST_POS = 3'(ALIVE_BYTES - 1);
    localparam logic [2:0] LENGTH_POS     = 3'(HEADER_BYTES - 1);

    // keep-alive frames start with these three bytes
    localparam logic [7:0] ALIVE_PREFIX [3] = '{8'h01, 8'h01, 8'h00};

    typedef struct packed {
        logic [7:0] payload_byte;
        logic [7:0] packet_length;
        logic       last_of_packet;
        logic       empty_packet;
        logic       length_error;
    } result_t;

endpackage

// ----- rtl/scd_byte_if.sv -----
interface scd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// ----- rtl/scd_result_if.sv -----
interface scd_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic [7:0] packet_length;
    logic       last_of_packet;
    logic       empty_packet;
    logic       length_error;

    modport source (output valid, output payload_byte, output packet_length,
                    output last_of_packet, output empty_packet,
                    output length_error, input ready);
    modport sink   (input valid, input payload_byte, input packet_length,
                    input last_of_packet, input empty_packet,
                    input length_error, output ready);
endinterface

// ----- rtl/scd_in_stage.sv -----
module scd_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    scd_byte_if.sink   capture,
    input  logic       advance,
    output logic       held_valid,
    output logic [7:0] held_byte
);
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       take;

    // register is free when empty or drained this cycle
    assign capture.ready = !valid_reg || advance;
    assign take          = capture.valid && capture.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= capture.in_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;
endmodule

// ----- rtl/scd_parse.sv -----
module scd_parse #(
    parameter int MAX_PAYLOAD_LEN = scd_pkg::MAX_PAYLOAD_LEN_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  logic [7:0]      cur_byte,
    output logic            res_valid,
    output scd_pkg::result_t res
);
    import scd_pkg::*;

    localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD_LEN);

    logic [2:0] header_position_reg, header_position_next;
    logic       alive_match_reg, alive_match_next;
    logic       in_payload_reg, in_payload_next;
    logic [7:0] payload_left_reg, payload_left_next;
    logic [7:0] current_length_reg, current_length_next;
    logic       halted_reg, halted_next;
    logic       last;

    always_comb
    begin
        header_position_next = header_position_reg;
        alive_match_next     = alive_match_reg;
        in_payload_next      = in_payload_reg;
        payload_left_next    = payload_left_reg;
        current_length_next  = current_length_reg;
        halted_next          = halted_reg;
        res_valid            = 1'b0;
        res                  = '0;
        last                 = (payload_left_reg <= 8'd1);

        if (halted_reg)
        begin
            // dead until reset
        end
        else if (in_payload_reg)
        begin
            res_valid          = 1'b1;
            res.payload_byte   = cur_byte;
            res.packet_length  = current_length_reg;
            res.last_of_packet = last;
            if (last)
            begin
                in_payload_next   = 1'b0;
                payload_left_next = 8'd0;
            end
            else
            begin
                payload_left_next = payload_left_reg - 8'd1;
            end
        end
        else if (header_position_reg < ALIVE_LAST_POS)
        begin
            if (cur_byte != ALIVE_PREFIX[header_position_reg[1:0]])
            begin
                alive_match_next = 1'b0;
            end
            header_position_next = header_position_reg + 3'd1;
        end
        else if (header_position_reg == ALIVE_LAST_POS)
        begin
            // fourth byte of a keep-alive is dropped, restart the header
            if (alive_match_reg)
            begin
                header_position_next = 3'd0;
                alive_match_next     = 1'b1;
            end
            else
            begin
                header_position_next = header_position_reg + 3'd1;
            end
        end
        else if (header_position_reg < LENGTH_POS)
        begin
            header_position_next = header_position_reg + 3'd1;
        end
        else
        begin
            // length byte
            header_position_next = 3'd0;
            alive_match_next     = 1'b1;
            current_length_next  = cur_byte;
            if (cur_byte > MAX_LEN)
            begin
                halted_next       = 1'b1;
                res_valid         = 1'b1;
                res.packet_length = cur_byte;
                res.length_error  = 1'b1;
            end
            else if (cur_byte == 8'd0)
            begin
                res_valid          = 1'b1;
                res.last_of_packet = 1'b1;
                res.empty_packet   = 1'b1;
            end
            else
            begin
                in_payload_next   = 1'b1;
                payload_left_next = cur_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_position_reg <= 3'd0;
            alive_match_reg     <= 1'b1;
            in_payload_reg      <= 1'b0;
            payload_left_reg    <= 8'd0;
            current_length_reg  <= 8'd0;
            halted_reg          <= 1'b0;
        end
        else if (advance)
        begin
            header_position_reg <= header_position_next;
            alive_match_reg     <= alive_match_next;
            in_payload_reg      <= in_payload_next;
            payload_left_reg    <= payload_left_next;
            current_length_reg  <= current_length_next;
            halted_reg          <= halted_next;
        end
    end
endmodule

// ----- rtl/scd_out_stage.sv -----
module scd_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    scd_result_if.source     packet,
    input  logic             load,
    input  logic             res_valid,
    input  scd_pkg::result_t res,
    output logic             can_take
);
    import scd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign can_take = !valid_reg || packet.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = res_valid;
        end
        else if (packet.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && res_valid)
        begin
            data_reg <= res;
        end
    end

    assign packet.valid          = valid_reg;
    assign packet.payload_byte   = data_reg.payload_byte;
    assign packet.packet_length  = data_reg.packet_length;
    assign packet.last_of_packet = data_reg.last_of_packet;
    assign packet.empty_packet   = data_reg.empty_packet;
    assign packet.length_error   = data_reg.length_error;
endmodule

// ----- rtl/sniffer_capture_deframer_unit.sv -----
// Capture stream deframer.
// capture: raw capture bytes, one per transfer (valid/ready).
// packet:  one result per payload byte, one per empty packet, one per
//          length error; last_of_packet marks the end of a packet.
// Keep-alive frames (01 01 00 xx) and the 8-byte header give no result.
// A byte accepted on capture passes through the input register, then the
//   result register, before its result shows on packet.
// Throughput: one byte per cycle while packet keeps moving, set by the single
//   pass of header/payload counter logic between the two registers.
// A length above MAX_PAYLOAD_LEN gives an error result; after that every
//   byte is accepted and dropped until reset.
// Reset (rst_n, async, active low) empties both registers and restarts
//   header collection at byte 0; no clearing pass.
// When packet stalls, the result register holds and the input register
//   still takes one more byte; capture.ready then drops until packet
//   moves again. Nothing is lost or repeated.
module sniffer_capture_deframer_unit #(
    parameter int MAX_PAYLOAD_LEN = scd_pkg::MAX_PAYLOAD_LEN_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    scd_byte_if.sink     capture,
    scd_result_if.source packet
);
    import scd_pkg::*;

    logic       held_valid;
    logic [7:0] held_byte;
    logic       can_take;
    logic       advance;
    logic       res_valid;
    result_t    res;

    // a held byte moves on when the result register is free
    assign advance = held_valid && can_take;

    scd_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .capture    (capture),
        .advance    (advance),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    scd_parse #(
        .MAX_PAYLOAD_LEN (MAX_PAYLOAD_LEN)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .cur_byte  (held_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    scd_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .packet    (packet),
        .load      (advance),
        .res_valid (res_valid),
        .res       (res),
        .can_take  (can_take)
    );
endmodule

// ----- dv/scd_checker.sv -----
`timescale 1ns / 100ps

// Watches both channels, predicts the deframer output from every capture
// transfer and compares each packet transfer against the oldest prediction.
module scd_checker #(
    parameter int MAX_LEN = scd_pkg::MAX_PAYLOAD_LEN_DEFAULT
) (
    input  logic  clk,
    input  logic  rst_n,
    scd_byte_if   capture,
    scd_result_if packet,
    output int    fail_count,
    output int    pending
);
    import scd_pkg::*;

    // predictor state
    logic [2:0] hdr_pos;
    logic       prefix_ok;
    logic       passing;
    logic [7:0] bytes_left;
    logic [7:0] pkt_len;
    logic       stopped;

    result_t    expected_q [$];
    int         mismatches;

    // Returns 1 when the byte yields a packet result.
    function automatic bit deframe_byte(input logic [7:0] b, output result_t r);
        r = '0;
        if (stopped)
            return 1'b0;
        if (passing)
        begin
            r.payload_byte   = b;
            r.packet_length  = pkt_len;
            r.last_of_packet = (bytes_left <= 8'd1);
            if (bytes_left <= 8'd1)
            begin
                passing    = 1'b0;
                bytes_left = '0;
            end
            else
                bytes_left = bytes_left - 8'd1;
            return 1'b1;
        end
        if (hdr_pos < ALIVE_LAST_POS)
        begin
            if (b != ALIVE_PREFIX[hdr_pos])
                prefix_ok = 1'b0;
            hdr_pos = hdr_pos + 3'd1;
            return 1'b0;
        end
        if (hdr_pos == ALIVE_LAST_POS)
        begin
            // keep-alive tail: dropped whatever its value
            if (prefix_ok)
                hdr_pos = '0;
            else
                hdr_pos = hdr_pos + 3'd1;
            return 1'b0;
        end
        if (hdr_pos < LENGTH_POS)
        begin
            hdr_pos = hdr_pos + 3'd1;
            return 1'b0;
        end
        // length byte
        hdr_pos   = '0;
        prefix_ok = 1'b1;
        pkt_len   = b;
        if (b > MAX_LEN)
        begin
            stopped         = 1'b1;
            r.packet_length = b;
            r.length_error  = 1'b1;
            return 1'b1;
        end
        if (b == 8'd0)
        begin
            r.last_of_packet = 1'b1;
            r.empty_packet   = 1'b1;
            return 1'b1;
        end
        passing    = 1'b1;
        bytes_left = b;
        return 1'b0;
    endfunction

    function automatic int field_mismatch(input string name, input int want, input int seen);
        if (want != seen)
        begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t next_want;
        int      bad;
        if (!rst_n)
        begin
            hdr_pos    = '0;
            prefix_ok  = 1'b1;
            passing    = 1'b0;
            bytes_left = '0;
            pkt_len    = '0;
            stopped    = 1'b0;
            expected_q.delete();
            mismatches = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (packet.valid && packet.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("packet transfer with nothing expected: byte %0d len %0d",
                           packet.payload_byte, packet.packet_length);
                    mismatches++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    bad  = 0;
                    bad += field_mismatch("payload_byte", want.payload_byte,
                                          packet.payload_byte);
                    bad += field_mismatch("packet_length", want.packet_length,
                                          packet.packet_length);
                    bad += field_mismatch("last_of_packet", want.last_of_packet,
                                          packet.last_of_packet);
                    bad += field_mismatch("empty_packet", want.empty_packet,
                                          packet.empty_packet);
                    bad += field_mismatch("length_error", want.length_error,
                                          packet.length_error);
                    if (bad != 0)
                        mismatches++;
                end
            end
            if (capture.valid && capture.ready)
            begin
                if (deframe_byte(capture.in_byte, next_want))
                    expected_q.push_back(next_want);
            end
            fail_count <= mismatches;
            pending    <= expected_q.size();
        end
    end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps

// Stimulus and verdict for the capture deframer. Checking lives in
// scd_checker, which sits beside the DUT on the same two channels.
module tb_top;
    import scd_pkg::*;

    localparam int MAX_LEN     = MAX_PAYLOAD_LEN_DEFAULT;
    localparam int ITEMS       = 900;
    localparam int CYCLE_LIMIT = 200_000;
    // long receiver hold-off, counted from the end of reset
    localparam int HOLD_FROM   = 400;
    localparam int HOLD_LEN    = 300;
    // receiver switches pattern every this many cycles
    localparam int RX_PHASE    = 50;

    typedef enum logic [1:0] {
        RX_OPEN,    // always ready
        RX_COIN,    // ready half the time
        RX_SPARSE,  // ready one cycle in four
        RX_MOSTLY   // ready most of the time
    } rx_pattern_t;

    logic clk;
    logic rst_n;

    scd_byte_if   capture_bus ();
    scd_result_if packet_bus ();

    int fail_count;
    int pending;

    int burst_left;
    int bytes_sent;
    int cycle_count = 0;
    int rx_cycles;

    sniffer_capture_deframer_unit u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .capture (capture_bus),
        .packet  (packet_bus)
    );

    scd_checker #(
        .MAX_LEN (MAX_LEN)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .capture    (capture_bus),
        .packet     (packet_bus),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
        clk = 1'b0;

    always #4 clk = ~clk;

    // Hard stop in case the block wedges or a prediction never arrives.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver side. Cycles through a few ready patterns so stalls land on
    // every phase of a frame, with one long hold-off in the middle of the
    // run: the sender keeps offering bytes, so the two internal registers
    // fill and capture.ready has to drop.
    always @(posedge clk)
    begin
        rx_pattern_t pattern;
        pattern = rx_pattern_t'((rx_cycles / RX_PHASE) % 4);
        if (!rst_n)
        begin
            packet_bus.ready <= 1'b0;
            rx_cycles        <= 0;
        end
        else
        begin
            rx_cycles <= rx_cycles + 1;
            if (rx_cycles >= HOLD_FROM && rx_cycles < HOLD_FROM + HOLD_LEN)
                packet_bus.ready <= 1'b0;
            else
            begin
                case (pattern)
                    RX_OPEN:   packet_bus.ready <= 1'b1;
                    RX_COIN:   packet_bus.ready <= 1'($urandom_range(1));
                    RX_SPARSE: packet_bus.ready <= (rx_cycles % 4 == 0);
                    default:   packet_bus.ready <= ($urandom_range(4) != 0);
                endcase
            end
        end
    end

    // One capture transfer. The sender works in bursts; between bursts it
    // drops valid for a random gap (sometimes none, so some bursts run
    // back to back). valid is only lowered when a real gap follows, so it
    // never sees two assignments in one step.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                capture_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        capture_bus.valid   <= 1'b1;
        capture_bus.in_byte <= b;
        // ready is sampled before this edge's updates: a transfer happens
        // when it is high here.
        do
            @(posedge clk);
        while (!capture_bus.ready);
        burst_left--;
        bytes_sent++;
    endtask

    // 01 01 00 followed by any fourth byte: dropped whole.
    task automatic send_keepalive(input logic [7:0] tail);
        send_byte(ALIVE_PREFIX[0]);
        send_byte(ALIVE_PREFIX[1]);
        send_byte(ALIVE_PREFIX[2]);
        send_byte(tail);
    endtask

    // 8-byte header (first three bytes given, next four random, then the
    // length), followed by the payload when the length is legal.
    task automatic send_packet(input logic [7:0] h0, input logic [7:0] h1,
                               input logic [7:0] h2, input logic [7:0] len);
        send_byte(h0);
        send_byte(h1);
        send_byte(h2);
        repeat (4) send_byte(8'($urandom));
        send_byte(len);
        if (len <= MAX_LEN)
            repeat (len) send_byte(8'($urandom));
    endtask

    initial
    begin
        logic [7:0] h0;
        logic [7:0] h1;
        logic [7:0] h2;
        logic [7:0] len;
        int         pick;
        bit         want_max;

        rst_n               = 1'b0;
        capture_bus.valid   = 1'b0;
        capture_bus.in_byte = '0;
        burst_left          = 0;
        bytes_sent          = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: keep-alives with both extreme tails, an empty packet
        // with an all-zero prefix, and a near miss on the keep-alive
        // prefix that must be taken as a normal one-byte packet.
        send_keepalive(8'h00);
        send_keepalive(8'hFF);
        send_packet(8'h00, 8'h00, 8'h00, 8'd0);
        send_packet(ALIVE_PREFIX[0], ALIVE_PREFIX[1], 8'hFF, 8'd1);

        // Random frames. Mostly well-formed packets, some keep-alives and
        // headers that start like a keep-alive and then diverge. Lengths
        // are kept legal here; the one illegal length comes last since it
        // halts the block for good. The first random packet is max length.
        want_max = 1'b1;
        while (bytes_sent < ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 15)
                send_keepalive(8'($urandom));
            else
            begin
                h0 = 8'($urandom);
                h1 = 8'($urandom);
                h2 = 8'($urandom);
                if (pick < 30)
                begin
                    h0 = ALIVE_PREFIX[0];
                    if ($urandom_range(1) == 1)
                    begin
                        h1 = ALIVE_PREFIX[1];
                        h2 = 8'($urandom_range(1, 255));
                    end
                    else if (h1 == ALIVE_PREFIX[1])
                        h1 = ~h1;
                end
                // a random prefix must not turn into a keep-alive
                if (h0 == ALIVE_PREFIX[0] && h1 == ALIVE_PREFIX[1] && h2 == ALIVE_PREFIX[2])
                    h2 = 8'h80;
                pick = $urandom_range(99);
                if (want_max)
                    len = 8'(MAX_LEN);
                else if (pick < 10)
                    len = 8'd0;
                else if (pick < 15)
                    len = 8'($urandom_range(100, MAX_LEN));
                else
                    len = 8'($urandom_range(1, 12));
                want_max = 1'b0;
                send_packet(h0, h1, h2, len);
            end
        end

        // Length error: one error transfer, then everything is swallowed.
        send_packet(8'hA5, 8'($urandom), 8'($urandom), 8'($urandom_range(MAX_LEN + 1, 255)));
        repeat (12) send_byte(8'($urandom));

        capture_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        // input and result registers: let anything unexpected surface
        repeat (8) @(posedge clk);

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
